// ===== rtl/brds_pkg.sv =====
// ----------------------------------------------------------------------------
// brds_pkg
// Shared types and constants for the bump robot drive sequencer.
// ----------------------------------------------------------------------------
package brds_pkg;

    localparam int unsigned TimeW   = 16;
    localparam int unsigned LightW  = 10;
    localparam int unsigned DutyW   = 8;
    localparam int unsigned CountW  = 8;
    localparam int unsigned PatW    = 4;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDatW = 16;

    typedef enum logic [2:0] {
        MODE_REST    = 3'd0,
        MODE_SENSOR  = 3'd1,
        MODE_REVERSE = 3'd2,
        MODE_TURN    = 3'd3,
        MODE_FWD1    = 3'd4,
        MODE_FWD2    = 3'd5,
        MODE_FWD3    = 3'd6,
        MODE_FWD4    = 3'd7
    } t_mode;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_REVERSE_TIME    = 3'd0,
        CFG_TURN_TIME       = 3'd1,
        CFG_SPEED_STEP_TIME = 3'd2,
        CFG_LIGHT_THRESHOLD = 3'd3,
        CFG_DUTY_LOW        = 3'd4,
        CFG_DUTY_MID        = 3'd5,
        CFG_DUTY_HIGH       = 3'd6,
        CFG_DUTY_FULL       = 3'd7
    } t_cfg_idx;

    // Motor direction pin patterns
    localparam logic [PatW-1:0] PAT_OFF     = 4'd0;
    localparam logic [PatW-1:0] PAT_REVERSE = 4'd6;
    localparam logic [PatW-1:0] PAT_TURN    = 4'd10;
    localparam logic [PatW-1:0] PAT_FORWARD = 4'd9;

    // Register reset values
    localparam logic [TimeW-1:0]  RST_REVERSE_TIME    = 16'd500;
    localparam logic [TimeW-1:0]  RST_TURN_TIME       = 16'd5000;
    localparam logic [TimeW-1:0]  RST_SPEED_STEP_TIME = 16'd5000;
    localparam logic [LightW-1:0] RST_LIGHT_THRESHOLD = 10'd630;
    localparam logic [DutyW-1:0]  RST_DUTY_LOW        = 8'h40;
    localparam logic [DutyW-1:0]  RST_DUTY_MID        = 8'h59;
    localparam logic [DutyW-1:0]  RST_DUTY_HIGH       = 8'h80;
    localparam logic [DutyW-1:0]  RST_DUTY_FULL       = 8'hFF;

    typedef struct packed {
        logic [TimeW-1:0]  reverse_time;
        logic [TimeW-1:0]  turn_time;
        logic [TimeW-1:0]  speed_step_time;
        logic [LightW-1:0] light_threshold;
        logic [DutyW-1:0]  duty_low;
        logic [DutyW-1:0]  duty_mid;
        logic [DutyW-1:0]  duty_high;
        logic [DutyW-1:0]  duty_full;
    } t_cfg;

    typedef struct packed {
        logic              start_button;
        logic              bump_sensor;
        logic [LightW-1:0] light_sample;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        mode;
        logic [DutyW-1:0]  pwm_duty;
        logic [PatW-1:0]   motor_pattern;
        logic              green_led;
        logic              red_led;
        logic              white_led;
        logic [CountW-1:0] collision_total;
    } t_out_item;

endpackage

// ===== rtl/brds_cfg.sv =====
// ----------------------------------------------------------------------------
// brds_cfg
// Configuration register file: durations, light threshold and duty levels.
// ----------------------------------------------------------------------------
module brds_cfg
    import brds_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [CfgDatW-1:0] i_cfg_data,
    output t_cfg               o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reverse_time    <= RST_REVERSE_TIME;
            r_cfg.turn_time       <= RST_TURN_TIME;
            r_cfg.speed_step_time <= RST_SPEED_STEP_TIME;
            r_cfg.light_threshold <= RST_LIGHT_THRESHOLD;
            r_cfg.duty_low        <= RST_DUTY_LOW;
            r_cfg.duty_mid        <= RST_DUTY_MID;
            r_cfg.duty_high       <= RST_DUTY_HIGH;
            r_cfg.duty_full       <= RST_DUTY_FULL;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_REVERSE_TIME:    r_cfg.reverse_time    <= i_cfg_data;
                CFG_TURN_TIME:       r_cfg.turn_time       <= i_cfg_data;
                CFG_SPEED_STEP_TIME: r_cfg.speed_step_time <= i_cfg_data;
                CFG_LIGHT_THRESHOLD: r_cfg.light_threshold <= i_cfg_data[LightW-1:0];
                CFG_DUTY_LOW:        r_cfg.duty_low        <= i_cfg_data[DutyW-1:0];
                CFG_DUTY_MID:        r_cfg.duty_mid        <= i_cfg_data[DutyW-1:0];
                CFG_DUTY_HIGH:       r_cfg.duty_high       <= i_cfg_data[DutyW-1:0];
                CFG_DUTY_FULL:       r_cfg.duty_full       <= i_cfg_data[DutyW-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/brds_core.sv =====
// ----------------------------------------------------------------------------
// brds_core
// Mode sequencer state, next-state logic, output decode and result register.
// ----------------------------------------------------------------------------
module brds_core
    import brds_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_item_valid,
    input  t_in_item  i_item,
    output logic      o_take,
    output logic      o_res_valid,
    output t_out_item o_res,
    input  logic      i_res_stall
);

    t_mode             r_mode, n_mode;
    logic [TimeW-1:0]  r_time_left, n_time_left;
    logic [CountW-1:0] r_count, n_count;
    logic              r_res_valid;
    t_out_item         r_res, n_res;
    logic [TimeW-1:0]  tl_dec;
    logic              step;

    // result register frees up when empty or its transaction completes
    assign o_take      = i_item_valid && (!r_res_valid || !i_res_stall);
    assign step        = o_take;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    assign tl_dec = (r_time_left != '0) ? r_time_left - TimeW'(1) : '0;

    always_comb begin
        n_mode      = r_mode;
        n_time_left = r_time_left;
        n_count     = r_count;
        case (r_mode)
            MODE_REST: begin
                if (i_item.start_button) begin
                    n_mode      = MODE_SENSOR;
                    n_time_left = '0;
                end
            end
            MODE_SENSOR: begin
                if (i_item.bump_sensor) begin
                    n_count     = r_count + CountW'(1);
                    n_mode      = MODE_REVERSE;
                    n_time_left = i_cfg.reverse_time;
                end else begin
                    n_mode      = MODE_FWD1;
                    n_time_left = i_cfg.speed_step_time;
                end
            end
            MODE_FWD4: begin
                if (i_item.start_button) begin
                    n_mode      = MODE_REST;
                    n_time_left = '0;
                end else if (i_item.bump_sensor) begin
                    n_mode      = MODE_SENSOR;
                    n_time_left = '0;
                end
            end
            default: begin
                // timed modes: count down first, then start, timeout, bump
                n_time_left = tl_dec;
                if (i_item.start_button) begin
                    n_mode      = MODE_REST;
                    n_time_left = '0;
                end else if (tl_dec == '0) begin
                    case (r_mode)
                        MODE_REVERSE: begin
                            n_mode      = MODE_TURN;
                            n_time_left = i_cfg.turn_time;
                        end
                        MODE_TURN: begin
                            n_mode      = MODE_SENSOR;
                            n_time_left = '0;
                        end
                        MODE_FWD3: begin
                            n_mode      = MODE_FWD4;
                            n_time_left = '0;
                        end
                        default: begin
                            n_mode      = t_mode'(r_mode + 3'd1);
                            n_time_left = i_cfg.speed_step_time;
                        end
                    endcase
                end else if (i_item.bump_sensor &&
                             (r_mode inside {MODE_FWD1, MODE_FWD2, MODE_FWD3})) begin
                    n_mode      = MODE_SENSOR;
                    n_time_left = '0;
                end
            end
        endcase
    end

    // decode of the mode in effect after the tick
    always_comb begin
        n_res.mode            = n_mode;
        n_res.collision_total = n_count;
        n_res.pwm_duty        = '0;
        n_res.motor_pattern   = PAT_OFF;
        n_res.green_led       = 1'b0;
        n_res.red_led         = 1'b0;
        case (n_mode)
            MODE_REST: begin
                n_res.green_led = 1'b1;
                n_res.red_led   = 1'b1;
            end
            MODE_SENSOR: begin
                n_res.red_led = 1'b1;
            end
            MODE_REVERSE: begin
                n_res.pwm_duty      = i_cfg.duty_low;
                n_res.motor_pattern = PAT_REVERSE;
                n_res.red_led       = 1'b1;
            end
            MODE_TURN: begin
                n_res.pwm_duty      = i_cfg.duty_low;
                n_res.motor_pattern = PAT_TURN;
                n_res.red_led       = 1'b1;
            end
            MODE_FWD1: begin
                n_res.pwm_duty      = i_cfg.duty_low;
                n_res.motor_pattern = PAT_FORWARD;
                n_res.green_led     = 1'b1;
            end
            MODE_FWD2: begin
                n_res.pwm_duty      = i_cfg.duty_mid;
                n_res.motor_pattern = PAT_FORWARD;
                n_res.green_led     = 1'b1;
            end
            MODE_FWD3: begin
                n_res.pwm_duty      = i_cfg.duty_high;
                n_res.motor_pattern = PAT_FORWARD;
                n_res.green_led     = 1'b1;
            end
            default: begin
                n_res.pwm_duty      = i_cfg.duty_full;
                n_res.motor_pattern = PAT_FORWARD;
                n_res.green_led     = 1'b1;
            end
        endcase
        n_res.white_led = (n_mode == MODE_REST) ||
                          (i_item.light_sample > i_cfg.light_threshold);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_REST;
            r_time_left <= '0;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (step) begin
                r_mode      <= n_mode;
                r_time_left <= n_time_left;
                r_count     <= n_count;
                r_res_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= n_res;
        end
    end

    // untimed modes always hold a cleared countdown
    a_untimed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_REST || r_mode == MODE_SENSOR || r_mode == MODE_FWD4)
        |-> r_time_left == '0)
        else $error("countdown not clear in an untimed mode");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !step |=> $stable(r_mode) && $stable(r_count) && $stable(r_time_left))
        else $error("sequencer state moved without a transaction");

    a_collision_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_mode == MODE_SENSOR && i_item.bump_sensor)
        |=> r_count == $past(r_count) + CountW'(1) && r_mode == MODE_REVERSE)
        else $error("collision not counted on leaving sensor check");

    a_res_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_res.mode == r_mode && r_res.collision_total == r_count)
        else $error("result register disagrees with sequencer state");

endmodule

// ===== rtl/bump_robot_drive_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// bump_robot_drive_sequencer_unit
// Millisecond-tick drive sequencer for a bump-and-turn robot.
// ----------------------------------------------------------------------------
// One input transaction per millisecond tick carries the start button, the
// bump switch and a 10-bit light reading; each tick yields exactly one result
// transaction with the new mode, PWM duty, motor pattern, LEDs and the
// wrapping collision count.
// Both channels use valid/stall: a transaction completes when valid is high
// and stall is low. The configuration channel (valid/ready, index and data)
// is always ready and should only be written while no tick is in flight.
// An input transaction reaches the result transaction through an input
// register, then the mode update and output decode into the result register.
// Throughput is one tick per cycle, limited only by the result register.
// When the receiver stalls, the result register holds and the input register
// fills; input stall rises once both are occupied.
// Reset (synchronous, active low) puts the sequencer in rest, clears the
// countdown, collision count and valid flags, and loads config defaults.
// ----------------------------------------------------------------------------
module bump_robot_drive_sequencer_unit
    import brds_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [CfgDatW-1:0] i_cfg_data
);

    t_cfg     cfg;
    logic     r_in_valid;
    t_in_item r_in;
    logic     take;
    logic     in_accept;

    assign o_in_stall = r_in_valid && !take;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in;
        end
    end

    brds_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    brds_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item_valid (r_in_valid),
        .i_item       (r_in),
        .o_take       (take),
        .o_res_valid  (o_out_valid),
        .o_res        (o_out),
        .i_res_stall  (i_out_stall)
    );

    // a stalled input register must be holding a transaction
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && o_out_valid)
        else $error("input stalled with room in the pipeline");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !take) |=> r_in_valid && $stable(r_in))
        else $error("held input transaction lost");

    a_rest_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.mode == MODE_REST) |-> o_out.white_led && o_out.green_led)
        else $error("rest mode LEDs wrong");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bump robot drive sequencer unit.
// ----------------------------------------------------------------------------
// A scoreboard class carries its own model of the sequencer: mode, countdown,
// collision count and register copies. Every accepted tick is run through it
// and the expected result queued; every accepted result is checked field by
// field against the oldest entry. A short directed walk through the modes is
// followed by random phases under different register settings and with
// different amounts of idling on both channels.
// ----------------------------------------------------------------------------
module tb;
    import brds_pkg::*;

    localparam int unsigned CycleLimit   = 200000;
    localparam int unsigned SettleCycles = 8;

    class drive_sequencer_scoreboard;
        t_cfg              regs;
        t_mode             mode;
        logic [TimeW-1:0]  time_left;
        logic [CountW-1:0] collisions;
        t_out_item         pending_outputs[$];
        int unsigned       mismatches;
        int unsigned       results_checked;
        int unsigned       wraps;
        int unsigned       mode_ticks[8];

        function new();
            regs.reverse_time    = RST_REVERSE_TIME;
            regs.turn_time       = RST_TURN_TIME;
            regs.speed_step_time = RST_SPEED_STEP_TIME;
            regs.light_threshold = RST_LIGHT_THRESHOLD;
            regs.duty_low        = RST_DUTY_LOW;
            regs.duty_mid        = RST_DUTY_MID;
            regs.duty_high       = RST_DUTY_HIGH;
            regs.duty_full       = RST_DUTY_FULL;
            mode       = MODE_REST;
            time_left  = '0;
            collisions = '0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CfgDatW-1:0] data);
            case (idx)
                CFG_REVERSE_TIME:    regs.reverse_time    = data;
                CFG_TURN_TIME:       regs.turn_time       = data;
                CFG_SPEED_STEP_TIME: regs.speed_step_time = data;
                CFG_LIGHT_THRESHOLD: regs.light_threshold = data[LightW-1:0];
                CFG_DUTY_LOW:        regs.duty_low        = data[DutyW-1:0];
                CFG_DUTY_MID:        regs.duty_mid        = data[DutyW-1:0];
                CFG_DUTY_HIGH:       regs.duty_high       = data[DutyW-1:0];
                default:             regs.duty_full       = data[DutyW-1:0];
            endcase
        endfunction

        function void switch_mode(t_mode m, logic [TimeW-1:0] t);
            mode      = m;
            time_left = t;
        endfunction

        function t_out_item step_sequencer(t_in_item tick);
            t_out_item res;
            res = '0;
            case (mode)
                MODE_REST: begin
                    if (tick.start_button) switch_mode(MODE_SENSOR, '0);
                end
                MODE_SENSOR: begin
                    // start is ignored here
                    if (tick.bump_sensor) begin
                        collisions = collisions + CountW'(1);
                        if (collisions == '0) wraps++;
                        switch_mode(MODE_REVERSE, regs.reverse_time);
                    end else begin
                        switch_mode(MODE_FWD1, regs.speed_step_time);
                    end
                end
                MODE_FWD4: begin
                    if (tick.start_button) switch_mode(MODE_REST, '0);
                    else if (tick.bump_sensor) switch_mode(MODE_SENSOR, '0);
                end
                default: begin
                    // countdown saturates at zero, so a zero duration lasts one tick
                    if (time_left != '0) time_left = time_left - TimeW'(1);
                    if (tick.start_button) begin
                        switch_mode(MODE_REST, '0);
                    end else if (time_left == '0) begin
                        case (mode)
                            MODE_REVERSE: switch_mode(MODE_TURN, regs.turn_time);
                            MODE_TURN:    switch_mode(MODE_SENSOR, '0);
                            MODE_FWD1:    switch_mode(MODE_FWD2, regs.speed_step_time);
                            MODE_FWD2:    switch_mode(MODE_FWD3, regs.speed_step_time);
                            default:      switch_mode(MODE_FWD4, '0);
                        endcase
                    end else if (tick.bump_sensor && mode >= MODE_FWD1) begin
                        switch_mode(MODE_SENSOR, '0);
                    end
                end
            endcase

            mode_ticks[mode]++;
            res.mode            = mode;
            res.collision_total = collisions;
            case (mode)
                MODE_REST: begin
                    res.green_led = 1'b1;
                    res.red_led   = 1'b1;
                end
                MODE_SENSOR: res.red_led = 1'b1;
                MODE_REVERSE: begin
                    res.pwm_duty      = regs.duty_low;
                    res.motor_pattern = PAT_REVERSE;
                    res.red_led       = 1'b1;
                end
                MODE_TURN: begin
                    res.pwm_duty      = regs.duty_low;
                    res.motor_pattern = PAT_TURN;
                    res.red_led       = 1'b1;
                end
                default: begin
                    case (mode)
                        MODE_FWD1: res.pwm_duty = regs.duty_low;
                        MODE_FWD2: res.pwm_duty = regs.duty_mid;
                        MODE_FWD3: res.pwm_duty = regs.duty_high;
                        default:   res.pwm_duty = regs.duty_full;
                    endcase
                    res.motor_pattern = PAT_FORWARD;
                    res.green_led     = 1'b1;
                end
            endcase
            res.white_led = (mode == MODE_REST) || (tick.light_sample > regs.light_threshold);
            return res;
        endfunction

        function void note_tick(t_in_item tick);
            pending_outputs.push_back(step_sequencer(tick));
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_outputs.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                return;
            end
            want = pending_outputs.pop_front();
            results_checked++;
            compare_field("mode", 16'(want.mode), 16'(got.mode));
            compare_field("pwm_duty", 16'(want.pwm_duty), 16'(got.pwm_duty));
            compare_field("motor_pattern", 16'(want.motor_pattern), 16'(got.motor_pattern));
            compare_field("green_led", 16'(want.green_led), 16'(got.green_led));
            compare_field("red_led", 16'(want.red_led), 16'(got.red_led));
            compare_field("white_led", 16'(want.white_led), 16'(got.white_led));
            compare_field("collision_total", 16'(want.collision_total),
                          16'(got.collision_total));
        endfunction
    endclass

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    t_in_item           i_in        = '0;
    logic               i_out_stall = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic [CfgIdxW-1:0] i_cfg_index = '0;
    logic [CfgDatW-1:0] i_cfg_data  = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    t_out_item          o_out;
    logic               o_cfg_ready;

    drive_sequencer_scoreboard sb;
    int unsigned cycle_count = 0;
    int unsigned stall_pct   = 0;
    int unsigned hold_left   = 0;

    bump_robot_drive_sequencer_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // both channels observed at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) sb.note_tick(i_in);
            if (o_out_valid && !i_out_stall) sb.check_result(o_out);
        end
    end

    // result receiver: random stall, or a forced hold-off when requested
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left != 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    function automatic t_in_item tick_of(int start, int bump, int light);
        t_in_item t;
        t.start_button = start[0];
        t.bump_sensor  = bump[0];
        t.light_sample = light[LightW-1:0];
        return t;
    endfunction

    // start is pressed often in rest so that sequences get going
    function automatic t_in_item random_tick(int unsigned start_pct, int unsigned bump_pct);
        t_in_item    t;
        int unsigned sp;
        sp = (sb.mode == MODE_REST) ? 50 : start_pct;
        t.start_button = ($urandom_range(99) < sp);
        t.bump_sensor  = ($urandom_range(99) < bump_pct);
        case ($urandom_range(9))
            0:       t.light_sample = '0;
            1:       t.light_sample = '1;
            default: t.light_sample = LightW'($urandom_range(1023));
        endcase
        return t;
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [CfgDatW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic program_regs(logic [15:0] rev, logic [15:0] turn, logic [15:0] step,
                                logic [15:0] thr, logic [15:0] lo, logic [15:0] mid,
                                logic [15:0] hi, logic [15:0] full);
        write_reg(CFG_REVERSE_TIME, rev);
        write_reg(CFG_TURN_TIME, turn);
        write_reg(CFG_SPEED_STEP_TIME, step);
        write_reg(CFG_LIGHT_THRESHOLD, thr);
        write_reg(CFG_DUTY_LOW, lo);
        write_reg(CFG_DUTY_MID, mid);
        write_reg(CFG_DUTY_HIGH, hi);
        write_reg(CFG_DUTY_FULL, full);
        i_cfg_valid <= 1'b0;
    endtask

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_tick(t_in_item t);
        i_in_valid <= 1'b1;
        i_in       <= t;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        while (sb.pending_outputs.size() != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic run_phase(int unsigned n, int unsigned idle_pct, int unsigned rx_stall_pct,
                             int unsigned start_pct, int unsigned bump_pct,
                             int unsigned hold, bit pause_midway);
        stall_pct = rx_stall_pct;
        hold_left = hold;
        for (int unsigned i = 0; i < n; i++) begin
            if (pause_midway && i == n / 2) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
                while (sb.pending_outputs.size() != 0) @(negedge i_clk);
            end
            while ($urandom_range(99) < idle_pct) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
            end
            send_tick(random_tick(start_pct, bump_pct));
        end
        i_in_valid <= 1'b0;
        wait_for_drain();
    endtask

    initial begin
        sb = new();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed walk: zero reverse time, short turn and speed steps
        program_regs(16'd0, 16'd2, 16'd2, 16'd1023, 16'h0000, 16'h005A, 16'h00A5, 16'h00FF);
        send_tick(tick_of(0, 1, 1023));   // bump ignored in rest
        send_tick(tick_of(1, 0, 0));      // to sensor
        send_tick(tick_of(0, 1, 1023));   // collision, reverse
        send_tick(tick_of(0, 0, 512));    // zero duration reverse ends
        send_tick(tick_of(0, 1, 700));    // bump ignored while turning
        send_tick(tick_of(0, 0, 1));
        send_tick(tick_of(0, 0, 1022));   // forward one
        send_tick(tick_of(0, 0, 0));
        send_tick(tick_of(0, 1, 0));      // timeout wins over bump
        send_tick(tick_of(0, 0, 0));
        send_tick(tick_of(0, 1, 300));    // timeout to forward three wins over bump
        send_tick(tick_of(1, 0, 0));      // start in forward three, back to rest
        send_tick(tick_of(0, 0, 100));
        send_tick(tick_of(0, 0, 200));
        send_tick(tick_of(0, 0, 400));
        send_tick(tick_of(0, 0, 800));
        send_tick(tick_of(0, 0, 1000));
        send_tick(tick_of(0, 0, 1023));   // still in rest
        send_tick(tick_of(0, 0, 1023));
        send_tick(tick_of(1, 1, 0));      // start to sensor, bump ignored in rest
        send_tick(tick_of(1, 0, 5));      // held button
        send_tick(tick_of(1, 1, 5));
        send_tick(tick_of(1, 0, 5));      // start in rest, to sensor
        send_tick(tick_of(0, 0, 1023));
        i_in_valid <= 1'b0;
        wait_for_drain();

        // no idling, with a long receiver hold-off at the start
        program_regs(16'($urandom_range(1, 6)), 16'($urandom_range(1, 8)),
                     16'($urandom_range(1, 10)), 16'hFC00,
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        run_phase(150, 0, 0, 3, 25, 120, 1'b0);

        // collision heavy, sender mostly idle, forward speeds never time out
        program_regs(16'($urandom_range(0, 1)), 16'($urandom_range(0, 1)), 16'hFFFF,
                     16'($urandom_range(0, 1023)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)));
        run_phase(325, 88, 0, 1, 97, 0, 1'b0);

        // receiver mostly stalled, endless turn, sender pauses midway
        program_regs(16'($urandom_range(1, 4)), 16'hFFFF, 16'($urandom_range(1, 6)),
                     16'hFFFF, 16'h0000, 16'h00FF, 16'hFF00, 16'h0000);
        run_phase(150, 0, 88, 3, 25, 0, 1'b1);

        // collision heavy with both sides idling
        program_regs(16'd1, 16'd1, 16'd1, 16'($urandom_range(0, 1023)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        run_phase(325, 27, 27, 1, 97, 0, 1'b0);

        if (sb.pending_outputs.size() != 0) begin
            sb.mismatches++;
            $display("%0t: %0d expected results never arrived", $time,
                     sb.pending_outputs.size());
        end
        $display("Checked %0d results over five register settings; collision count wrapped %0d times",
                 sb.results_checked, sb.wraps);
        $display("Ticks per mode: rest %0d sensor %0d reverse %0d turn %0d fwd %0d/%0d/%0d/%0d",
                 sb.mode_ticks[0], sb.mode_ticks[1], sb.mode_ticks[2], sb.mode_ticks[3],
                 sb.mode_ticks[4], sb.mode_ticks[5], sb.mode_ticks[6], sb.mode_ticks[7]);
        if (sb.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/brds_pkg.sv
rtl/brds_cfg.sv
rtl/brds_core.sv
rtl/bump_robot_drive_sequencer_unit.sv
verif/tb.sv
